FILE: sv/tlnf_pkg.sv
// Shared types and character constants for the text line numbering filter.
package tlnf_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_NUMBER_ALL       = 3'd0;
    localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd1;
    localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [2:0] REG_SHOW_ENDS        = 3'd3;
    localparam logic [2:0] REG_SHOW_TABS        = 3'd4;
    localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd5;

    // Character codes
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_I        = 8'h49;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CTRL_MAX    = 8'd31;
    localparam logic [7:0] CARET_SHIFT = 8'd64;

    // Saturation point of the blank line run count
    localparam logic [1:0] BLANK_RUN_MAX = 2'd2;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

    // One classified byte as handed from front to back
    typedef struct packed {
        logic       num_en;
        logic       pre_en;
        logic [7:0] pre_byte;
        logic [7:0] main_byte;
    } cmd_t;

    // Front status seen at the top level
    typedef struct packed {
        logic line_start;
        logic push;
    } fr_stat_t;

endpackage

FILE: sv/tlnf_front.sv
// Front end: accepts input bytes, tracks line state and line number, classifies bytes.
module tlnf_front
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,    // [7:0] in_byte
    input  logic                       full,
    output cmd_t                       wr_cmd,
    output logic [4*NUMBER_DIGITS-1:0] wr_digits,
    output fr_stat_t                   stat
);

    localparam int DW = 4 * NUMBER_DIGITS;
    localparam logic [DW-1:0] DIGITS_ONE = DW'(1) << (4 * (NUMBER_DIGITS - 1));

    logic          line_start_reg;
    logic [1:0]    blank_cnt_reg;
    logic [1:0]    blank_cnt_next;
    logic [DW-1:0] digits_reg;
    logic [DW-1:0] digits_next;
    logic          nl;
    logic          is_tab;
    logic          blank;
    logic          drop;
    logic          accept;
    logic          count_en;

    assign nl       = (s_tdata == CH_LF);
    assign is_tab   = (s_tdata == CH_TAB);
    assign blank    = line_start_reg && nl;
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // Blank run count as it stands after this byte
    always_comb
    begin
        blank_cnt_next = blank_cnt_reg;
        if (line_start_reg)
        begin
            if (nl)
                blank_cnt_next = (blank_cnt_reg == BLANK_RUN_MAX) ? BLANK_RUN_MAX
                                                                 : blank_cnt_reg + 2'd1;
            else
                blank_cnt_next = 2'd0;
        end
    end

    assign drop     = line_start_reg && cfg.squeeze_blank && (blank_cnt_next > 2'd1);
    assign count_en = line_start_reg && !drop && (!blank || !cfg.number_nonblank);

    // Classify the byte into an optional number, an optional prefix and a main byte
    always_comb
    begin
        wr_cmd.num_en    = line_start_reg &&
                           ((cfg.number_all && !cfg.number_nonblank) ||
                            (cfg.number_nonblank && !blank));
        wr_cmd.pre_en    = 1'b0;
        wr_cmd.pre_byte  = CH_CARET;
        wr_cmd.main_byte = s_tdata;
        if (cfg.show_tabs && is_tab)
        begin
            wr_cmd.pre_en    = 1'b1;
            wr_cmd.main_byte = CH_I;
        end
        else if (cfg.show_ends && nl && !(cfg.number_nonblank && blank))
        begin
            wr_cmd.pre_en   = 1'b1;
            wr_cmd.pre_byte = CH_DOLLAR;
        end
        else if (cfg.show_nonprinting && !nl && !is_tab)
        begin
            if (s_tdata != 8'd0 && s_tdata <= CTRL_MAX)
            begin
                wr_cmd.pre_en    = 1'b1;
                wr_cmd.main_byte = s_tdata + CARET_SHIFT;
            end
            else if (s_tdata == CH_DEL)
            begin
                wr_cmd.pre_en    = 1'b1;
                wr_cmd.main_byte = CH_QMARK;
            end
        end
    end

    // Decimal increment of the line number, holding at all nines
    always_comb
    begin
        logic       carry;
        logic       all_nine;
        logic [3:0] d;
        carry       = 1'b1;
        all_nine    = 1'b1;
        digits_next = digits_reg;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            d        = digits_reg[4*i +: 4];
            all_nine = all_nine && (d == 4'd9);
            if (carry)
            begin
                if (d == 4'd9)
                    digits_next[4*i +: 4] = 4'd0;
                else
                begin
                    digits_next[4*i +: 4] = d + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nine)
            digits_next = digits_reg;
    end

    assign wr_digits       = digits_reg;
    assign stat.push       = accept && !drop;
    assign stat.line_start = line_start_reg;

    // Advance line state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= 1'b1;
            blank_cnt_reg  <= 2'd0;
            digits_reg     <= DIGITS_ONE;
        end
        else if (accept)
        begin
            line_start_reg <= nl;
            blank_cnt_reg  <= blank_cnt_next;
            if (count_en)
                digits_reg <= digits_next;
        end
    end

endmodule

FILE: sv/tlnf_fifo.sv
// Short queue between the front end and the back end.
module tlnf_fifo #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

FILE: sv/tlnf_back.sv
// Back end: expands each classified byte into output bytes, one per cycle when not stalled.
module tlnf_back
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_valid,
    input  cmd_t                       rd_cmd,
    input  logic [4*NUMBER_DIGITS-1:0] rd_digits,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,    // [7:0] out_byte
    output logic                       m_tlast     // last_of_run
);

    localparam int DW = 4 * NUMBER_DIGITS;
    localparam int PW = $clog2(NUMBER_DIGITS + 3);
    localparam logic [PW-1:0] POS_LAST_DIGIT = PW'(NUMBER_DIGITS - 1);
    localparam logic [PW-1:0] POS_TAB        = PW'(NUMBER_DIGITS);
    localparam logic [PW-1:0] POS_PRE        = PW'(NUMBER_DIGITS + 1);
    localparam logic [PW-1:0] POS_MAIN       = PW'(NUMBER_DIGITS + 2);

    cmd_t          cur_reg;
    logic [DW-1:0] digits_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] pos_start;
    logic          cur_valid_reg;
    logic          lead_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic          adv;
    logic          at_main;
    logic [3:0]    digit;
    logic          digit_zero;
    logic [7:0]    byte_now;

    assign adv        = cur_valid_reg && (!out_valid_reg || m_tready);
    assign at_main    = (pos_reg == POS_MAIN);
    assign pop        = rd_valid && (!cur_valid_reg || (adv && at_main));
    assign digit      = digits_reg[3:0];
    assign digit_zero = (digit == 4'd0);

    // Pick the byte at the current position
    always_comb
    begin
        if (at_main)
            byte_now = cur_reg.main_byte;
        else if (pos_reg == POS_PRE)
            byte_now = cur_reg.pre_byte;
        else if (pos_reg == POS_TAB)
            byte_now = CH_TAB;
        else if (lead_reg && digit_zero && pos_reg != POS_LAST_DIGIT)
            byte_now = CH_SPACE;
        else
            byte_now = CH_ZERO + {4'd0, digit};
    end

    // Step to the next position, skipping an absent prefix
    always_comb
    begin
        if (pos_reg == POS_TAB)
            pos_next = cur_reg.pre_en ? POS_PRE : POS_MAIN;
        else
            pos_next = pos_reg + PW'(1);
    end

    always_comb
    begin
        if (rd_cmd.num_en)
            pos_start = '0;
        else if (rd_cmd.pre_en)
            pos_start = POS_PRE;
        else
            pos_start = POS_MAIN;
    end

    // Load the current entry and walk through its bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
        end
        else if (adv && at_main)
        begin
            cur_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg    <= rd_cmd;
            digits_reg <= rd_digits;
            pos_reg    <= pos_start;
            lead_reg   <= 1'b1;
        end
        else if (adv)
        begin
            pos_reg    <= pos_next;
            digits_reg <= digits_reg >> 4;
            lead_reg   <= lead_reg && digit_zero;
        end
    end

    // Output register: hold while stalled, refill when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg <= byte_now;
            out_last_reg <= at_main;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: sv/text_line_numbering_filter.sv
// Top level of the text line numbering filter with its configuration registers.
//
// Input stream (s_tvalid/s_tready/s_tdata) carries one raw text byte per transfer.
// Output stream (m_tvalid/m_tready/m_tdata/m_tlast) carries formatted bytes; m_tlast
// marks the final byte caused by one input byte. A squeezed blank line gives no output.
// Each input byte expands into 1 to NUMBER_DIGITS+3 output bytes: an optional line
// number and tab, an optional prefix ('$' or '^'), and the byte itself.
// The back end sends one output byte per cycle while the receiver does not stall it.
// The front end takes a byte every cycle while the 4-entry queue has room, so
// expansion bursts are absorbed there before the input stalls.
// An input byte is held in the queue, then in the back end's current entry, then in the output register.
// When the receiver stalls, the output register holds its byte, the back end and
// then the queue fill, and s_tready drops once the queue is full.
// Reset clears the options, puts the block at the start of a line, sets the line
// number to 1 and empties the queue. Options sit at APB byte address 4*index;
// the user sets them only while the block is idle; the block does not enforce it.
module text_line_numbering_filter
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW    = 4 * NUMBER_DIGITS;
    localparam int CMDW  = $bits(cmd_t);
    localparam int WIDTH = CMDW + DW;
    localparam int DEPTH = 4;

    cfg_t             cfg_reg;
    logic             reg_bit;
    logic             full;
    logic             pop;
    logic             rd_valid;
    cmd_t             wr_cmd;
    logic [DW-1:0]    wr_digits;
    logic [WIDTH-1:0] rd_data;
    fr_stat_t         fr_stat;

    assign pready = 1'b1;

    // Write option registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[4:2])
                REG_NUMBER_ALL:       cfg_reg.number_all       <= pwdata[0];
                REG_NUMBER_NONBLANK:  cfg_reg.number_nonblank  <= pwdata[0];
                REG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= pwdata[0];
                REG_SHOW_ENDS:        cfg_reg.show_ends        <= pwdata[0];
                REG_SHOW_TABS:        cfg_reg.show_tabs        <= pwdata[0];
                REG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back option registers
    always_comb
    begin
        unique case (paddr[4:2])
            REG_NUMBER_ALL:       reg_bit = cfg_reg.number_all;
            REG_NUMBER_NONBLANK:  reg_bit = cfg_reg.number_nonblank;
            REG_SQUEEZE_BLANK:    reg_bit = cfg_reg.squeeze_blank;
            REG_SHOW_ENDS:        reg_bit = cfg_reg.show_ends;
            REG_SHOW_TABS:        reg_bit = cfg_reg.show_tabs;
            REG_SHOW_NONPRINTING: reg_bit = cfg_reg.show_nonprinting;
            default:              reg_bit = 1'b0;
        endcase
    end

    assign prdata = {31'd0, reg_bit};

    tlnf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .full      (full),
        .wr_cmd    (wr_cmd),
        .wr_digits (wr_digits),
        .stat      (fr_stat)
    );

    tlnf_fifo #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fr_stat.push),
        .wr_data  ({wr_cmd, wr_digits}),
        .full     (full),
        .pop      (pop),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    tlnf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_valid  (rd_valid),
        .rd_cmd    (cmd_t'(rd_data[WIDTH-1 -: CMDW])),
        .rd_digits (rd_data[DW-1:0]),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fr_stat.push |-> !full)
        else $error("queue written while full");

    // Only a byte at the start of a line can be dropped
    a_drop_at_line_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !fr_stat.line_start) |-> fr_stat.push)
        else $error("mid-line byte dropped");

    // A line number is requested only at the start of a line
    a_number_at_line_start: assert property (@(posedge clk) disable iff (!rst_n)
        (fr_stat.push && !fr_stat.line_start) |-> !wr_cmd.num_en)
        else $error("line number requested mid-line");

    // The queue never offers data to the back end after reset without a push
    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(rd_valid)) |-> $past(fr_stat.push))
        else $error("queue became valid without a push");

endmodule

FILE: bench/tb_text_line_numbering_filter.sv
// Self-checking testbench for the text line numbering filter with a built-in line formatter.
`timescale 1ns / 100ps

module tb_text_line_numbering_filter;
    import tlnf_pkg::*;

    localparam int DIGITS        = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 500000;

    // One formatted output byte as seen on the master side
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;    // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] out_byte
    logic        m_tlast;            // last_of_run
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = 5'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Raw bytes waiting for the input stream, formatted bytes awaited on the output
    logic [7:0]  text_bytes[$];
    out_beat_t   expected_out[$];

    // Formatter shadow: options and line state
    cfg_t        opts;
    logic        at_line_start;
    logic [3:0]  line_digits[DIGITS];
    logic [1:0]  blank_runs;

    logic        in_done     = 1'b0;
    logic        in_idle_en  = 1'b0;
    logic        out_idle_en = 1'b0;
    int          in_gap      = 0;
    int          out_stall   = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    text_line_numbering_filter #(
        .NUMBER_DIGITS (DIGITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Format one raw byte and queue the output bytes it should produce
    function automatic void format_text_byte(input logic [7:0] c);
        logic [7:0] run[$];
        logic [7:0] shown;
        logic       is_lf;
        logic       blank;
        logic       lead;
        logic       all_nines;
        logic       carry;
        out_beat_t  beat;
        int         i;
        is_lf = (c == CH_LF);
        blank = 1'b0;
        shown = c;
        if (at_line_start)
        begin
            blank = is_lf;
            if (blank)
            begin
                if (blank_runs < BLANK_RUN_MAX)
                    blank_runs++;
            end
            else
                blank_runs = '0;
            // Drop a repeated blank line entirely; the next byte still starts a line
            if (opts.squeeze_blank && blank_runs == BLANK_RUN_MAX)
                return;
            if ((opts.number_all && !opts.number_nonblank) || (opts.number_nonblank && !blank))
            begin
                lead = 1'b1;
                for (i = 0; i < DIGITS; i++)
                begin
                    if (line_digits[i] != 4'd0 || i == DIGITS - 1)
                        lead = 1'b0;
                    run.push_back(lead ? CH_SPACE : CH_ZERO + {4'd0, line_digits[i]});
                end
                run.push_back(CH_TAB);
            end
            // Advance the decimal line count, holding at all nines
            if (!blank || !opts.number_nonblank)
            begin
                all_nines = 1'b1;
                for (i = 0; i < DIGITS; i++)
                    if (line_digits[i] != 4'd9)
                        all_nines = 1'b0;
                carry = !all_nines;
                for (i = DIGITS - 1; i >= 0; i--)
                begin
                    if (carry)
                    begin
                        if (line_digits[i] == 4'd9)
                            line_digits[i] = 4'd0;
                        else
                        begin
                            line_digits[i] = line_digits[i] + 4'd1;
                            carry = 1'b0;
                        end
                    end
                end
            end
        end
        if (opts.show_tabs && c == CH_TAB)
        begin
            run.push_back(CH_CARET);
            run.push_back(CH_I);
        end
        else
        begin
            if (opts.show_ends && is_lf && !(opts.number_nonblank && blank))
                run.push_back(CH_DOLLAR);
            if (opts.show_nonprinting && !is_lf && c != CH_TAB)
            begin
                if (c >= 8'd1 && c <= CTRL_MAX)
                begin
                    run.push_back(CH_CARET);
                    shown = c + CARET_SHIFT;
                end
                else if (c == CH_DEL)
                begin
                    run.push_back(CH_CARET);
                    shown = CH_QMARK;
                end
            end
            run.push_back(shown);
        end
        at_line_start = is_lf;
        for (i = 0; i < run.size(); i++)
        begin
            beat.data = run[i];
            beat.last = (i == run.size() - 1);
            expected_out.push_back(beat);
        end
    endfunction

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Write one option register; leaves the bus in its access phase
    task automatic reg_write(input logic [2:0] idx, input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Load a new option set and idling mode while the block is idle
    task automatic start_phase(input cfg_t c, input logic idle_in, input logic idle_out);
        reg_write(REG_NUMBER_ALL,       c.number_all);
        reg_write(REG_NUMBER_NONBLANK,  c.number_nonblank);
        reg_write(REG_SQUEEZE_BLANK,    c.squeeze_blank);
        reg_write(REG_SHOW_ENDS,        c.show_ends);
        reg_write(REG_SHOW_TABS,        c.show_tabs);
        reg_write(REG_SHOW_NONPRINTING, c.show_nonprinting);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        opts        = c;
        in_idle_en  = idle_in;
        out_idle_en = idle_out;
    endtask

    // Wait until every queued byte is sent and every output byte has arrived
    task automatic drain();
        while (text_bytes.size() != 0 || s_tvalid || expected_out.size() != 0)
            @(negedge clk);
        // Let squeezed lines still in the pipeline clear out
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Present queued bytes on the input stream with random gaps
    always @(negedge clk)
    begin : input_driver
        if (rst_n && (!s_tvalid || in_done))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                s_tvalid <= 1'b0;
            end
            else if (text_bytes.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= text_bytes.pop_front();
                in_gap = (in_idle_en && $urandom_range(0, 99) < 30) ? idle_length() : 0;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Stall the output stream at random
    always @(negedge clk)
    begin : output_receiver
        if (out_stall > 0)
        begin
            out_stall--;
            m_tready <= 1'b0;
        end
        else if (out_idle_en && $urandom_range(0, 99) < 25)
        begin
            out_stall = idle_length() - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin : monitor
        out_beat_t beat;
        in_done = rst_n && s_tvalid && s_tready;
        if (in_done)
            format_text_byte(s_tdata);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
            begin
                $error("unexpected output transfer: out_byte=%02h last_of_run=%0b",
                       m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                beat = expected_out.pop_front();
                if (m_tdata !== beat.data)
                begin
                    $error("out_byte: expected %02h, actual %02h", beat.data, m_tdata);
                    error_count++;
                end
                if (m_tlast !== beat.last)
                begin
                    $error("last_of_run: expected %0b, actual %0b", beat.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        cfg_t       c;
        logic [7:0] b;
        int         ph;
        int         count;
        int         len;
        int         r;
        int         sel;
        opts          = '0;
        at_line_start = 1'b1;
        blank_runs    = '0;
        for (int i = 0; i < DIGITS; i++)
            line_digits[i] = 4'd0;
        line_digits[DIGITS - 1] = 4'd1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset options: everything passes through, the count still advances
        text_bytes.push_back("A");
        text_bytes.push_back(CH_TAB);
        text_bytes.push_back(8'h01);
        text_bytes.push_back(CH_DEL);
        text_bytes.push_back(8'h00);
        text_bytes.push_back(8'hFF);
        text_bytes.push_back(8'h80);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back(CH_LF);
        drain();

        // All options on: nonblank numbering wins, blank runs squeezed, no '$' on blanks
        start_phase(cfg_t'(6'b111111), 1'b1, 1'b1);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back("x");
        text_bytes.push_back(CH_TAB);
        text_bytes.push_back(8'h1F);
        text_bytes.push_back(CH_DEL);
        text_bytes.push_back(8'h1B);
        text_bytes.push_back(CH_LF);
        drain();

        // Number every line, blank lines get '$'; tab passes with caret notation on
        c = '0;
        c.number_all       = 1'b1;
        c.show_ends        = 1'b1;
        c.show_nonprinting = 1'b1;
        start_phase(c, 1'b0, 1'b1);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back(CH_TAB);
        text_bytes.push_back(8'h7E);
        text_bytes.push_back(CH_SPACE);
        text_bytes.push_back(CH_LF);
        drain();

        // Random text: mostly lines with mixed content and blank runs, some noise
        for (ph = 0; ph < 6; ph++)
        begin
            if (ph == 0)
                start_phase(cfg_t'(6'b000000), 1'b1, 1'b1);
            else if (ph == 5)
                start_phase(cfg_t'(6'b111111), 1'b0, 1'b0);
            else
                start_phase(cfg_t'(6'($urandom_range(0, 63))), $urandom_range(0, 3) != 0,
                            $urandom_range(0, 3) != 0);
            count = 0;
            while (count < 43)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    text_bytes.push_back(8'($urandom_range(0, 255)));
                    count++;
                end
                else if (r < 30)
                begin
                    len = $urandom_range(1, 4);
                    repeat (len) text_bytes.push_back(CH_LF);
                    count += len;
                end
                else
                begin
                    len = $urandom_range(1, 10);
                    repeat (len)
                    begin
                        sel = $urandom_range(0, 99);
                        if (sel < 60)
                            b = 8'($urandom_range(32, 126));
                        else if (sel < 70)
                            b = CH_TAB;
                        else if (sel < 80)
                        begin
                            b = 8'($urandom_range(1, 31));
                            if (b == CH_LF)
                                b = CH_TAB;
                        end
                        else if (sel < 85)
                            b = CH_DEL;
                        else if (sel < 90)
                            b = 8'h00;
                        else
                            b = 8'($urandom_range(128, 255));
                        text_bytes.push_back(b);
                    end
                    text_bytes.push_back(CH_LF);
                    count += len + 1;
                end
            end
            drain();
        end

        if (error_count == 0 && expected_out.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
